// ----- sv/ip_range_access_filter_core_defines.svh -----
// Assertion macros used by the checker of the range filter.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef IP_RANGE_ACCESS_FILTER_CORE_DEFINES_SVH
`define IP_RANGE_ACCESS_FILTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IRAF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IRAF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/iraf_pkg.sv -----
package iraf_pkg;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 9;

	// Operation codes carried on func. Code 3 is unused and is served by default arms.
	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_LOOKUP = 2'd2
	} func_t;

	// One stored range as it sits in a word of the table memory.
	typedef struct packed {
		logic [ADDR_W-1:0] low;
		logic [ADDR_W-1:0] high;
		logic              deny;
	} range_entry_t;

	localparam int ENTRY_W = $bits(range_entry_t);

endpackage

// ----- sv/iraf_ram.sv -----
module iraf_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port; the read data is registered from the read address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/ip_range_access_filter_core.sv -----
// Channel | Direction | Handshake            | Payload
// in      | request   | in_valid / in_ready  | func, range_start, range_end, deny_flag, query_addr
// out     | result    | out_valid / out_ready| blocked, status, entry_count
//
// A clear, an append, an unused code or a lookup that needs no scan passes through the
// execute and done states to the result register; a scanning lookup also passes through
// the scan state, where the range memory's single read port delivers one stored range per cycle.
// Reset empties the table at once by clearing the held count; the memory itself is not swept.
// One request is processed at a time and in_ready is high only while the block is idle, which
// it may be while the last result still waits; a result that cannot move in holds the block.
module ip_range_access_filter_core
	import iraf_pkg::*;
#(
	parameter int MAX_RANGES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [ADDR_W-1:0] range_start,
	input  logic [ADDR_W-1:0] range_end,
	input  logic              deny_flag,
	input  logic [ADDR_W-1:0] query_addr,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              blocked,
	output logic              status,
	output logic [COUNT_W-1:0] entry_count
);

	// The table address needs enough bits for the depth; the held count must also reach the
	// depth itself, so it is one value wider.
	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	// The accepted request is held here for the whole of its processing.
	logic [1:0]        func_q;
	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] end_q;
	logic              deny_q;
	logic [ADDR_W-1:0] addr_q;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      issue_q;
	logic               rd_valid_s1;
	logic               deny_hit_q;
	logic               allow_hit_q;
	logic               res_blocked_q;
	logic               res_status_q;
	logic               out_valid_q;
	logic               blocked_q;
	logic               status_q;
	logic [COUNT_W-1:0] count_out_q;

	logic               table_full;
	logic               mem_we;
	logic               mem_re;
	range_entry_t       wr_entry;
	range_entry_t       rd_entry;
	logic [ENTRY_W-1:0] rd_word;
	logic               covered;
	logic [CW+COUNT_W-1:0] count_ext;

	assign table_full = (count_q == CW'(MAX_RANGES));
	assign in_ready   = (state_q == ST_IDLE);

	// An append writes the slot just past the last held range, unless the table is full.
	assign mem_we = (state_q == ST_EXEC) && (func_q == FUNC_APPEND) && !table_full;
	assign wr_entry.low  = start_q;
	assign wr_entry.high = end_q;
	assign wr_entry.deny = deny_q;

	// During a scan one held range is read per cycle, from slot zero up to one below the count.
	assign mem_re = (state_q == ST_SCAN) && (issue_q < count_q);

	iraf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_RANGES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_entry),
		.re    (mem_re),
		.raddr (issue_q[AW-1:0]),
		.rdata (rd_word)
	);

	// Bounds are inclusive; a range whose start lies above its end covers nothing.
	assign rd_entry = range_entry_t'(rd_word);
	assign covered  = (addr_q >= rd_entry.low) && (addr_q <= rd_entry.high);

	// The reported count is the held count taken to nine bits.
	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_q  <= func;
			start_q <= range_start;
			end_q   <= range_end;
			deny_q  <= deny_flag;
			addr_q  <= query_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			issue_q       <= '0;
			rd_valid_s1   <= 1'b0;
			deny_hit_q    <= 1'b0;
			allow_hit_q   <= 1'b0;
			res_blocked_q <= 1'b0;
			res_status_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			blocked_q     <= 1'b0;
			status_q      <= 1'b0;
			count_out_q   <= '0;
		end else begin
			rd_valid_s1 <= mem_re;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					res_blocked_q <= 1'b0;
					res_status_q  <= 1'b0;
					state_q       <= ST_DONE;
					case (func_q)
						FUNC_CLEAR: begin
							count_q <= '0;
						end
						FUNC_APPEND: begin
							if (table_full) begin
								res_status_q <= 1'b1;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						FUNC_LOOKUP: begin
							// An empty table lets everything pass; with any range held,
							// address zero is refused without a scan.
							if (count_q == '0) begin
								res_blocked_q <= 1'b0;
							end else if (addr_q == '0) begin
								res_blocked_q <= 1'b1;
							end else begin
								issue_q     <= '0;
								deny_hit_q  <= 1'b0;
								allow_hit_q <= 1'b0;
								state_q     <= ST_SCAN;
							end
						end
						default: begin
							// The unused code changes nothing and reports the count.
						end
					endcase
				end

				ST_SCAN: begin
					if (mem_re) begin
						issue_q <= issue_q + CW'(1);
					end
					if (rd_valid_s1) begin
						if (covered && rd_entry.deny) begin
							deny_hit_q <= 1'b1;
						end
						if (covered && !rd_entry.deny) begin
							allow_hit_q <= 1'b1;
						end
					end
					// Once every read is issued and the last word has been judged, any deny
					// hit blocks, and an address covered by no range at all is blocked too.
					if (!mem_re && !rd_valid_s1) begin
						res_blocked_q <= deny_hit_q || !allow_hit_q;
						state_q       <= ST_DONE;
					end
				end

				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						blocked_q   <= res_blocked_q;
						status_q    <= res_status_q;
						count_out_q <= count_ext[COUNT_W-1:0];
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign blocked     = blocked_q;
	assign status      = status_q;
	assign entry_count = count_out_q;

endmodule

// ----- sv/iraf_checker.sv -----
`include "ip_range_access_filter_core_defines.svh"

module iraf_checker
	import iraf_pkg::*;
#(
	parameter int MAX_RANGES = 256
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               blocked,
	input logic               status,
	input logic [COUNT_W-1:0] entry_count
);

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAX_RANGES);
	localparam bit COUNT_WRAPS = (MAX_RANGES >= (1 << COUNT_W));

	`IRAF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(blocked) && $stable(status) && $stable(entry_count), "result changed while stalled")
	`IRAF_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while one is in progress")
	`IRAF_ASSERT_SAME(a_drop_not_lookup, out_valid && status, !blocked, "dropped append reported as blocked")
	`IRAF_ASSERT_SAME(a_drop_when_full, out_valid && status, entry_count == FULL_COUNT, "append dropped below a full table")
	`IRAF_ASSERT_SAME(a_count_bound, out_valid && !COUNT_WRAPS, entry_count <= FULL_COUNT, "count above the table depth")

endmodule

bind ip_range_access_filter_core iraf_checker #(.MAX_RANGES(MAX_RANGES)) u_iraf_checker (.*);

// ----- dv/ip_range_access_filter_core_verdict_check.sv -----
module ip_range_access_filter_core_verdict_check
	import iraf_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         func,
	input  logic [ADDR_W-1:0]  range_start,
	input  logic [ADDR_W-1:0]  range_end,
	input  logic               deny_flag,
	input  logic [ADDR_W-1:0]  query_addr,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               blocked,
	input  logic               status,
	input  logic [COUNT_W-1:0] entry_count,
	output int                 fail_count,
	output int                 pending,
	output int                 results_seen,
	output int                 lookups_seen,
	output int                 blocks_seen,
	output int                 drops_seen
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               blocked;
		logic               status;
		logic [COUNT_W-1:0] entry_count;
	} verdict_t;

	// Own copy of the range table; only entries below span_count are ever read.
	logic [ADDR_W-1:0] span_low  [TABLE_DEPTH];
	logic [ADDR_W-1:0] span_high [TABLE_DEPTH];
	logic              span_deny [TABLE_DEPTH];
	int                span_count = 0;
	verdict_t          verdicts_due [$];

	int fails   = 0;
	int results = 0;
	int lookups = 0;
	int blocks  = 0;
	int drops   = 0;

	function automatic logic lookup_verdict(logic [ADDR_W-1:0] addr);
		logic verdict;
		verdict = 1'b1;
		if (span_count == 0)
			return 1'b0;
		if (addr == '0)
			return 1'b1;
		for (int k = 0; k < span_count; k++) begin
			if (addr >= span_low[k] && addr <= span_high[k]) begin
				if (span_deny[k])
					return 1'b1;
				verdict = 1'b0;
			end
		end
		return verdict;
	endfunction

	function automatic verdict_t apply_request(logic [1:0] op, logic [ADDR_W-1:0] lo,
			logic [ADDR_W-1:0] hi, logic deny, logic [ADDR_W-1:0] addr);
		verdict_t v;
		v = '0;
		case (op)
			FUNC_CLEAR: span_count = 0;
			FUNC_APPEND: begin
				if (span_count < TABLE_DEPTH) begin
					span_low[span_count]  = lo;
					span_high[span_count] = hi;
					span_deny[span_count] = deny;
					span_count++;
				end else begin
					v.status = 1'b1;
					drops++;
				end
			end
			FUNC_LOOKUP: begin
				v.blocked = lookup_verdict(addr);
				lookups++;
				if (v.blocked)
					blocks++;
			end
			default: ;
		endcase
		v.entry_count = COUNT_W'(span_count);
		return v;
	endfunction

	// Results are taken before requests so that a result leaving at the same edge as a new
	// request arrives is matched against the older expectation.
	always @(posedge clk) begin : watch
		verdict_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results++;
				if (verdicts_due.size() == 0) begin
					$error("result with no request outstanding: blocked %0b status %0b count %0d",
						blocked, status, entry_count);
					fails++;
				end else begin
					want = verdicts_due.pop_front();
					if (blocked !== want.blocked) begin
						$error("blocked: expected %0b, got %0b", want.blocked, blocked);
						fails++;
					end
					if (status !== want.status) begin
						$error("status: expected %0b, got %0b", want.status, status);
						fails++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
						fails++;
					end
				end
			end
			if (in_valid && in_ready)
				verdicts_due.insert(verdicts_due.size(), apply_request(func, range_start,
					range_end, deny_flag, query_addr));
		end
		fail_count   <= fails;
		pending      <= verdicts_due.size();
		results_seen <= results;
		lookups_seen <= lookups;
		blocks_seen  <= blocks;
		drops_seen   <= drops;
	end

endmodule

// ----- dv/ip_range_access_filter_core_test.sv -----
module ip_range_access_filter_core_test;

	timeunit 1ns;
	timeprecision 1ps;

	import iraf_pkg::*;

	localparam int         TABLE_DEPTH  = 256;
	localparam int         RANDOM_ITEMS = 450;
	localparam int         LIMIT_CYCLES = 1_000_000;
	localparam int         HOLD_CYCLES  = 300;
	// The fourth operation code has no name in the package; the block must treat it as a no-op.
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;

	typedef struct {
		logic [ADDR_W-1:0] low;
		logic [ADDR_W-1:0] high;
	} span_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         func;
	logic [ADDR_W-1:0]  range_start;
	logic [ADDR_W-1:0]  range_end;
	logic               deny_flag;
	logic [ADDR_W-1:0]  query_addr;
	logic               out_valid;
	logic               out_ready;
	logic               blocked;
	logic               status;
	logic [COUNT_W-1:0] entry_count;

	int fail_count;
	int pending;
	int results_seen;
	int lookups_seen;
	int blocks_seen;
	int drops_seen;
	int items_sent = 0;
	int cycles     = 0;

	// Ranges offered since the last clear, kept only so that lookups can aim at them.
	span_t offered_spans [$];

	ip_range_access_filter_core #(
		.MAX_RANGES(TABLE_DEPTH)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.range_start(range_start),
		.range_end  (range_end),
		.deny_flag  (deny_flag),
		.query_addr (query_addr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.blocked    (blocked),
		.status     (status),
		.entry_count(entry_count)
	);

	ip_range_access_filter_core_verdict_check #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) verdicts (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.range_start (range_start),
		.range_end   (range_end),
		.deny_flag   (deny_flag),
		.query_addr  (query_addr),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.blocked     (blocked),
		.status      (status),
		.entry_count (entry_count),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen),
		.lookups_seen(lookups_seen),
		.blocks_seen (blocks_seen),
		.drops_seen  (drops_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog. The slowest correct run is a few hundred requests, each at worst a full-table
	// scan plus idling, so the cycle limit leaves a wide margin.
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("ip_range_access_filter_core_test: FAIL");
		$finish;
	end

	// Result side. It idles now and then, keeps a stretch of results with no idling at all,
	// and once holds off for a long while so that the block fills up and must refuse requests.
	initial begin : result_sink
		int hold_left;
		bit held_once;
		hold_left = 0;
		held_once = 1'b0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_once && results_seen >= 60) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (results_seen >= 200 && results_seen < 300) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 7);
			end
		end
	end

	// Offers one request and returns once it has been accepted. The idle gap is placed before
	// valid rises, so valid is never lowered and raised again within one time step. Requests
	// numbered 200 to 299 go out back to back.
	task automatic send_request(input logic [1:0] op, input logic [ADDR_W-1:0] lo,
			input logic [ADDR_W-1:0] hi, input logic deny, input logic [ADDR_W-1:0] addr);
		while (!(items_sent >= 200 && items_sent < 300) && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= op;
		range_start <= lo;
		range_end   <= hi;
		deny_flag   <= deny;
		query_addr  <= addr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (op == FUNC_CLEAR)
			offered_spans.delete();
		else if (op == FUNC_APPEND)
			offered_spans.insert(offered_spans.size(), '{low: lo, high: hi});
	endtask

	// The fields that an operation ignores still carry random values.
	task automatic send_clear();
		send_request(FUNC_CLEAR, $urandom, $urandom, 1'($urandom), $urandom);
	endtask

	task automatic send_append(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
			input logic deny);
		send_request(FUNC_APPEND, lo, hi, deny, $urandom);
	endtask

	task automatic send_lookup(input logic [ADDR_W-1:0] addr);
		send_request(FUNC_LOOKUP, $urandom, $urandom, 1'($urandom), addr);
	endtask

	// The sender stops offering until every request sent so far has produced its result. It
	// waits on the clock first, since the checker's count of outstanding requests is registered.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Appends one range near base. Most ranges are narrow, a quarter are single hosts, a few
	// are very wide (clipped at the top of the address space) and some are reversed, which
	// must cover nothing at all.
	task automatic offer_random_span(input logic [ADDR_W-1:0] base);
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		logic [ADDR_W:0]   reach;
		int                shape;
		lo    = base + $urandom_range(4095);
		shape = $urandom_range(99);
		if (shape < 25)
			reach = {1'b0, lo};
		else if (shape < 65)
			reach = {1'b0, lo} + $urandom_range(255);
		else if (shape < 85)
			reach = {1'b0, lo} + $urandom_range(1 << 20);
		else
			reach = {1'b0, lo} + $urandom;
		hi = reach[ADDR_W] ? '1 : reach[ADDR_W-1:0];
		if (shape >= 92) begin
			lo = lo | 32'h0000_1000;
			hi = lo - 1 - $urandom_range(255);
		end
		send_append(lo, hi, $urandom_range(99) < 35);
	endtask

	// Lookups mostly aim at the bounds of offered ranges, just outside them or somewhere
	// inside, with address zero, the top address and wholly random addresses mixed in.
	function automatic logic [ADDR_W-1:0] pick_address();
		span_t           s;
		int              pick;
		logic [ADDR_W:0] width;
		pick = $urandom_range(99);
		if (offered_spans.size() == 0 || pick < 8)
			return $urandom;
		if (pick < 14)
			return '0;
		if (pick < 18)
			return '1;
		s = offered_spans[$urandom_range(offered_spans.size() - 1)];
		case ($urandom_range(4))
			0: return s.low;
			1: return s.high;
			2: return s.low - 1;
			3: return s.high + 1;
			default: begin
				if (s.high < s.low)
					return s.low;
				width = {1'b0, s.high} - s.low + 1;
				return s.low + ADDR_W'({1'b0, $urandom} % width);
			end
		endcase
	endfunction

	initial begin : stimulus
		int                random_goal;
		int                seq;
		logic [ADDR_W-1:0] base;

		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		func        <= FUNC_CLEAR;
		range_start <= '0;
		range_end   <= '0;
		deny_flag   <= 1'b0;
		query_addr  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. An empty table lets everything through, address zero included, and
		// the unused operation code must leave the table alone.
		send_lookup('0);
		send_lookup('1);
		send_request(FUNC_UNUSED, $urandom, $urandom, 1'b1, $urandom);

		// An allow range with a single denied host inside it, a reversed range, an allow range
		// at the very top of the address space and one that starts at address zero.
		send_append(32'h0A00_0000, 32'h0A00_00FF, 1'b0);
		send_append(32'h0A00_0080, 32'h0A00_0080, 1'b1);
		send_append(32'h2000_0000, 32'h1FFF_FFFF, 1'b0);
		send_append(32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b0);
		send_append(32'h0000_0000, 32'h0000_0010, 1'b0);

		// Address zero is blocked once the table holds anything, even though a range covers
		// it. The remaining lookups probe both bounds, the denied host, the first address past a
		// range, the start of the reversed one, the top address and one inside the range at zero.
		send_lookup('0);
		send_lookup(32'h0A00_0000);
		send_lookup(32'h0A00_00FF);
		send_lookup(32'h0A00_0080);
		send_lookup(32'h0A00_0100);
		send_lookup(32'h2000_0000);
		send_lookup('1);
		send_lookup(32'h0000_0001);
		send_request(FUNC_UNUSED, $urandom, $urandom, 1'b0, $urandom);

		// After a clear the table is empty again; then one deny range over everything.
		send_clear();
		send_lookup('0);
		send_append('0, '1, 1'b1);
		send_lookup('1);
		send_lookup(32'h8000_0000);

		wait_drained();

		// Random part. Most of it is made of well-formed sequences: an optional clear, a few
		// ranges clustered round one base, then lookups aimed at them. One sequence fills the
		// table to the brim and goes on appending, so that full-table drops occur and lookups
		// scan every entry. The rest is noise on every operation code with random fields.
		random_goal = items_sent + RANDOM_ITEMS;
		seq = 0;
		while (items_sent < random_goal) begin
			if (seq == 3) begin
				send_clear();
				repeat (TABLE_DEPTH + 3)
					offer_random_span($urandom);
				repeat (6)
					send_lookup(pick_address());
				send_request(FUNC_UNUSED, $urandom, $urandom, 1'($urandom), $urandom);
				wait_drained();
			end else if ($urandom_range(99) < 20) begin
				repeat ($urandom_range(1, 4))
					send_request(2'($urandom_range(3)), $urandom, $urandom, 1'($urandom),
						$urandom);
			end else begin
				if ($urandom_range(99) < 70)
					send_clear();
				base = $urandom;
				repeat ($urandom_range(1, 8))
					offer_random_span(base);
				repeat ($urandom_range(2, 8)) begin
					if ($urandom_range(99) < 6)
						send_request(FUNC_UNUSED, $urandom, $urandom, 1'($urandom), $urandom);
					else
						send_lookup(pick_address());
				end
			end
			seq++;
		end

		// Let every result come home, then keep the clock running so that anything unexpected
		// can still appear.
		wait_drained();
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("Sent %0d requests and checked %0d results: %0d lookups (%0d blocked).",
			items_sent, results_seen, lookups_seen, blocks_seen);
		$display("The table was filled to capacity and %0d appends to it were dropped.",
			drops_seen);
		if (fail_count == 0 && pending == 0)
			$display("ip_range_access_filter_core_test: PASS");
		else
			$display("ip_range_access_filter_core_test: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/iraf_pkg.sv
sv/iraf_ram.sv
sv/ip_range_access_filter_core.sv
sv/iraf_checker.sv
dv/ip_range_access_filter_core_verdict_check.sv
dv/ip_range_access_filter_core_test.sv
